FILE: hw/rtl/rc5_tx_pkg.sv
package rc5_tx_pkg;

  localparam int HALF_BITS_PER_MESSAGE_DEF = 28;
  localparam int MESSAGE_BITS_DEF          = 14;

  localparam int BASE_W     = 14;
  localparam int FRAME_W    = 8;
  localparam int DEBOUNCE_W = 4;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_MESSAGE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HALF_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_FRAMES = 2'd2;

  localparam logic [BASE_W-1:0]     BASE_MESSAGE_RST    = 14'h3188;
  localparam logic [FRAME_W-1:0]    FRAME_HALF_BITS_RST = 8'd128;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_FRAMES_RST = 4'd3;

  localparam logic [31:0] TOGGLE_MASK = 32'h0000_0800;

  localparam logic        FUNC_TICK  = 1'b0;
  localparam logic        FUNC_PRESS = 1'b1;
  localparam logic [1:0]  BUTTON_2   = 2'd2;

  typedef struct packed {
    logic       func;
    logic [1:0] button_id;
    logic       button_1_level;
    logic       button_2_level;
  } rc5_in_t;

  typedef struct packed {
    logic carrier_on;
    logic sending;
    logic button_1_irq_on;
    logic button_2_irq_on;
  } rc5_out_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } rc5_cfg_wr_t;

endpackage

FILE: hw/rtl/rc5_tx_core.sv
module rc5_tx_core import rc5_tx_pkg::*; #(
  parameter int HALF_BITS_PER_MESSAGE = HALF_BITS_PER_MESSAGE_DEF,
  parameter int MESSAGE_BITS          = MESSAGE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rc5_cfg_wr_t cfg_wr,
  input  logic        step,
  input  rc5_in_t     item,
  output rc5_out_t    result_nxt
);

  localparam int HB_W  = $clog2(HALF_BITS_PER_MESSAGE + 1);
  localparam logic [HB_W-1:0] HB_RELOAD = HB_W'(HALF_BITS_PER_MESSAGE);
  localparam logic [MESSAGE_BITS-1:0] MSG_RST = MESSAGE_BITS'(32'(BASE_MESSAGE_RST));

  logic [BASE_W-1:0]       base_message_r;
  logic [FRAME_W-1:0]      frame_half_bits_r;
  logic [DEBOUNCE_W-1:0]   debounce_frames_r;

  logic [MESSAGE_BITS-1:0] message_word_r, message_word_nxt;
  logic                    toggle_bit_r, toggle_bit_nxt;
  logic [FRAME_W-1:0]      frame_count_r, frame_count_nxt;
  logic [HB_W-1:0]         half_bit_count_r, half_bit_count_nxt;
  logic [DEBOUNCE_W-1:0]   debounce_count_r, debounce_count_nxt;
  logic                    running_r, running_nxt;
  logic [1:0]              irq_enables_r, irq_enables_nxt;
  logic                    carrier_r, carrier_nxt;

  logic [31:0]             rebuilt;
  logic [DEBOUNCE_W-1:0]   debounce_dec;
  logic [HB_W-1:0]         bit_idx;
  logic [31:0]             msg_shift;
  logic                    tx_bit;
  logic [1:0]              irq_bit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_message_r    <= BASE_MESSAGE_RST;
      frame_half_bits_r <= FRAME_HALF_BITS_RST;
      debounce_frames_r <= DEBOUNCE_FRAMES_RST;
    end else if (cfg_wr.we) begin
      unique case (cfg_wr.idx)
        REG_BASE_MESSAGE:    base_message_r    <= cfg_wr.data[BASE_W-1:0];
        REG_FRAME_HALF_BITS: frame_half_bits_r <= cfg_wr.data[FRAME_W-1:0];
        REG_DEBOUNCE_FRAMES: debounce_frames_r <= cfg_wr.data[DEBOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rebuilt = 32'(base_message_r) ^ (toggle_bit_r ? TOGGLE_MASK : 32'd0);
    if (!item.button_1_level) rebuilt = rebuilt | 32'd1;
    if (!item.button_2_level) rebuilt = rebuilt | 32'd2;
    debounce_dec = (debounce_count_r != '0) ? debounce_count_r - 1'b1 : debounce_count_r;
    bit_idx   = (half_bit_count_r - 1'b1) >> 1;
    msg_shift = 32'(message_word_r) >> bit_idx;
    tx_bit    = msg_shift[0];
    irq_bit   = (item.button_id == BUTTON_2) ? 2'b10 : 2'b01;

    message_word_nxt   = message_word_r;
    toggle_bit_nxt     = toggle_bit_r;
    frame_count_nxt    = frame_count_r;
    half_bit_count_nxt = half_bit_count_r;
    debounce_count_nxt = debounce_count_r;
    running_nxt        = running_r;
    irq_enables_nxt    = irq_enables_r;
    carrier_nxt        = carrier_r;

    if (step) begin
      if (item.func == FUNC_PRESS) begin
        if ((irq_enables_r & irq_bit) != 2'b00) begin
          message_word_nxt = MESSAGE_BITS'(32'(message_word_r) | 32'(item.button_id));
          running_nxt      = 1'b1;
          irq_enables_nxt  = irq_enables_r & ~irq_bit;
        end
      end else if (running_r) begin
        if (frame_count_r == '0) begin
          // frame end
          frame_count_nxt    = frame_half_bits_r;
          half_bit_count_nxt = HB_RELOAD;
          debounce_count_nxt = debounce_dec;
          message_word_nxt   = MESSAGE_BITS'(rebuilt);
          if (debounce_dec == '0 && item.button_1_level && item.button_2_level) begin
            toggle_bit_nxt     = ~toggle_bit_r;
            message_word_nxt   = MESSAGE_BITS'(rebuilt ^ TOGGLE_MASK);
            debounce_count_nxt = debounce_frames_r;
            running_nxt        = 1'b0;
            carrier_nxt        = 1'b0;
            irq_enables_nxt    = 2'b11;
          end
        end else begin
          if (half_bit_count_r != '0) begin
            carrier_nxt        = ~tx_bit ^ half_bit_count_r[0];
            half_bit_count_nxt = half_bit_count_r - 1'b1;
          end else begin
            carrier_nxt = 1'b0;
          end
          frame_count_nxt = frame_count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      message_word_r   <= MSG_RST;
      toggle_bit_r     <= 1'b0;
      frame_count_r    <= FRAME_HALF_BITS_RST;
      half_bit_count_r <= HB_RELOAD;
      debounce_count_r <= DEBOUNCE_FRAMES_RST;
      running_r        <= 1'b0;
      irq_enables_r    <= 2'b11;
      carrier_r        <= 1'b0;
    end else begin
      message_word_r   <= message_word_nxt;
      toggle_bit_r     <= toggle_bit_nxt;
      frame_count_r    <= frame_count_nxt;
      half_bit_count_r <= half_bit_count_nxt;
      debounce_count_r <= debounce_count_nxt;
      running_r        <= running_nxt;
      irq_enables_r    <= irq_enables_nxt;
      carrier_r        <= carrier_nxt;
    end
  end

  assign result_nxt.carrier_on      = carrier_nxt;
  assign result_nxt.sending         = running_nxt;
  assign result_nxt.button_1_irq_on = irq_enables_nxt[0];
  assign result_nxt.button_2_irq_on = irq_enables_nxt[1];

endmodule

FILE: hw/rtl/rc5_manchester_frame_transmitter.sv
// Channel   Dir  Handshake             Payload
// in_       in   in_valid/in_ready     rc5_in_t   (tick or button press request)
// out_      out  out_valid/out_ready   rc5_out_t  (state after the request)
// cfg_      in   cfg_we                cfg_idx, cfg_data
//
// One request per cycle while in_ready is high; each result is registered
// and shown in the next cycle. The result register is the only output stage:
// in_ready drops only while a result is held and out_ready is low.
// Synchronous active-low reset loads the register defaults and idle state.
module rc5_manchester_frame_transmitter import rc5_tx_pkg::*; #(
  parameter int HALF_BITS_PER_MESSAGE = HALF_BITS_PER_MESSAGE_DEF,
  parameter int MESSAGE_BITS          = MESSAGE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rc5_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rc5_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic        out_valid_r;
  rc5_out_t    out_data_r;
  rc5_out_t    result_nxt;
  rc5_cfg_wr_t cfg_wr;
  logic        step;

  assign in_ready    = !out_valid_r || out_ready;
  assign step        = in_valid && in_ready;
  assign cfg_wr.we   = cfg_we;
  assign cfg_wr.idx  = cfg_idx;
  assign cfg_wr.data = cfg_data;

  rc5_tx_core #(
    .HALF_BITS_PER_MESSAGE(HALF_BITS_PER_MESSAGE),
    .MESSAGE_BITS         (MESSAGE_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .step      (step),
    .item      (in_data),
    .result_nxt(result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: dv/tb_rc5_manchester_frame_transmitter.sv
module tb_rc5_manchester_frame_transmitter;
  import rc5_tx_pkg::*;

  class rc5_tx_scoreboard;
    logic [BASE_W-1:0]     base_msg;
    logic [FRAME_W-1:0]    frame_len;
    logic [DEBOUNCE_W-1:0] debounce_len;

    logic [BASE_W-1:0]     msg;
    bit                    toggle;
    logic [FRAME_W-1:0]    frame_cnt;
    int                    half_cnt;
    logic [DEBOUNCE_W-1:0] debounce_cnt;
    bit                    running;
    logic [1:0]            irq_en;
    bit                    carrier;

    rc5_out_t expected_states[$];
    int errors;

    function new();
      base_msg     = BASE_MESSAGE_RST;
      frame_len    = FRAME_HALF_BITS_RST;
      debounce_len = DEBOUNCE_FRAMES_RST;
      msg          = BASE_MESSAGE_RST;
      toggle       = 1'b0;
      frame_cnt    = 8'd128;
      half_cnt     = HALF_BITS_PER_MESSAGE_DEF;
      debounce_cnt = 4'd3;
      running      = 1'b0;
      irq_en       = 2'b11;
      carrier      = 1'b0;
      errors       = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BASE_MESSAGE:    base_msg = data[BASE_W-1:0];
        REG_FRAME_HALF_BITS: frame_len = data[FRAME_W-1:0];
        REG_DEBOUNCE_FRAMES: debounce_len = data[DEBOUNCE_W-1:0];
        default: ;
      endcase
    endfunction

    function void close_frame(bit b1, bit b2);
      frame_cnt = frame_len;
      half_cnt  = HALF_BITS_PER_MESSAGE_DEF;
      if (debounce_cnt != 0) debounce_cnt = debounce_cnt - 1'b1;
      msg = base_msg;
      if (toggle) msg = msg ^ TOGGLE_MASK[BASE_W-1:0];
      if (!b1) msg[0] = 1'b1;
      if (!b2) msg[1] = 1'b1;
      if (debounce_cnt != 0) return;
      if (b1 && b2) begin
        toggle       = ~toggle;
        msg          = msg ^ TOGGLE_MASK[BASE_W-1:0];
        debounce_cnt = debounce_len;
        running      = 1'b0;
        carrier      = 1'b0;
        irq_en       = 2'b11;
      end
    endfunction

    function void half_bit_tick(bit b1, bit b2);
      int idx;
      if (frame_cnt == 0) begin
        close_frame(b1, b2);
        return;
      end
      if (half_cnt != 0) begin
        idx     = (half_cnt + 1) / 2 - 1;
        carrier = ~msg[idx] ^ half_cnt[0];
        half_cnt--;
      end else begin
        carrier = 1'b0;
      end
      frame_cnt = frame_cnt - 1'b1;
    endfunction

    // returns 0 when the block ignores the request
    function bit note_request(rc5_in_t r);
      bit         took;
      logic [1:0] irq_bit;
      rc5_out_t   e;
      took = 1'b1;
      if (r.func == FUNC_PRESS) begin
        irq_bit = (r.button_id == BUTTON_2) ? 2'b10 : 2'b01;
        if ((irq_en & irq_bit) == 2'b00) begin
          took = 1'b0;
        end else begin
          msg     = msg | {{(BASE_W-2){1'b0}}, r.button_id};
          running = 1'b1;
          irq_en  = irq_en & ~irq_bit;
        end
      end else if (running) begin
        half_bit_tick(r.button_1_level, r.button_2_level);
      end else begin
        took = 1'b0;
      end
      e.carrier_on      = carrier;
      e.sending         = running;
      e.button_1_irq_on = irq_en[0];
      e.button_2_irq_on = irq_en[1];
      expected_states.push_back(e);
      return took;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_result(rc5_out_t got);
      rc5_out_t e;
      if (expected_states.size() == 0) begin
        report("result with no request pending");
        return;
      end
      e = expected_states.pop_front();
      if (got.carrier_on !== e.carrier_on)
        report($sformatf("carrier_on got %b exp %b", got.carrier_on, e.carrier_on));
      if (got.sending !== e.sending)
        report($sformatf("sending got %b exp %b", got.sending, e.sending));
      if (got.button_1_irq_on !== e.button_1_irq_on)
        report($sformatf("button_1_irq_on got %b exp %b",
                         got.button_1_irq_on, e.button_1_irq_on));
      if (got.button_2_irq_on !== e.button_2_irq_on)
        report($sformatf("button_2_irq_on got %b exp %b",
                         got.button_2_irq_on, e.button_2_irq_on));
    endtask

    function int pending();
      return expected_states.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  rc5_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  rc5_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_BASE_MESSAGE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rc5_tx_scoreboard sb = new();
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int stall_left = 0;

  rc5_manchester_frame_transmitter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) rx_steady <= ~rx_steady;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
      stall_left <= pick_gap() - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic rc5_in_t make_request(logic func, logic [1:0] id, logic b1, logic b2);
    rc5_in_t r;
    r.func           = func;
    r.button_id      = id;
    r.button_1_level = b1;
    r.button_2_level = b2;
    return r;
  endfunction

  function automatic rc5_in_t pick_request();
    rc5_in_t r;
    r = make_request(FUNC_TICK, 2'($urandom_range(0, 3)),
                     $urandom_range(0, 99) < 80, $urandom_range(0, 99) < 80);
    if (!sb.running) begin
      if ($urandom_range(0, 99) < 85) r.func = FUNC_PRESS;
    end else if ($urandom_range(0, 99) < 6) begin
      r.func = FUNC_PRESS;
    end
    return r;
  endfunction

  task send(input rc5_in_t r, output bit took);
    int gap;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    took = sb.note_request(r);
    if ($urandom_range(0, 99) < 2) tx_steady = ~tx_steady;
    gap = 0;
    if (!tx_steady && $urandom_range(0, 99) < 30) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task wait_drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task write_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    sb.write_register(idx, CFG_DATA_W'(value));
  endtask

  task set_registers(int unsigned base, int unsigned frame, int unsigned deb);
    wait_drain();
    write_register(REG_BASE_MESSAGE, base);
    write_register(REG_FRAME_HALF_BITS, frame);
    write_register(REG_DEBOUNCE_FRAMES, deb);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task run_phase(int count);
    int      done_cnt;
    bit      took;
    rc5_in_t r;
    done_cnt = 0;
    while (done_cnt < count) begin
      if ($urandom_range(0, 99) == 0) wait_drain();
      r = pick_request();
      send(r, took);
      if (took) done_cnt++;
    end
  endtask

  task run_directed();
    bit took;
    int k;
    send(make_request(FUNC_TICK, 2'd1, 1'b0, 1'b0), took);  // stopped: ignored
    send(make_request(FUNC_TICK, 2'd2, 1'b1, 1'b1), took);
    send(make_request(FUNC_PRESS, 2'd1, 1'b0, 1'b1), took);
    send(make_request(FUNC_PRESS, 2'd0, 1'b1, 1'b0), took);  // masked via button 1
    send(make_request(FUNC_PRESS, 2'd2, 1'b0, 1'b0), took);
    send(make_request(FUNC_PRESS, 2'd3, 1'b1, 1'b1), took);  // masked
    send(make_request(FUNC_PRESS, 2'd2, 1'b1, 1'b1), took);  // masked
    for (k = 0; k < 18; k++)
      send(make_request(FUNC_TICK, 2'(k), k[0], k[1]), took);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_phase(250);
    set_registers(0, 28, 0);
    run_phase(250);
    set_registers(14'h3FFF, 255, 15);
    run_phase(200);
    set_registers($urandom_range(0, 16383), 10, 1);   // frame shorter than message
    run_phase(200);
    set_registers($urandom_range(0, 16383), 0, 2);
    run_phase(150);
    set_registers($urandom_range(0, 16383), $urandom_range(28, 40), $urandom_range(0, 4));
    run_phase(350);
    set_registers($urandom_range(0, 16383), $urandom_range(28, 60), $urandom_range(0, 2));
    run_phase(350);
    wait_drain();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
